FILE: rtl/srclex_pkg.sv
package srclex_pkg;

    localparam int OFFSET_BITS   = 24;
    localparam int LINE_BITS     = 16;
    localparam int KIND_BITS     = 6;
    localparam int SPAN_BITS     = 24;
    localparam int LINE_OUT_BITS = 16;

    localparam logic [OFFSET_BITS-1:0] OFF_TOP  = {OFFSET_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_TOP = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

    // source bytes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LCUR   = 8'h7B;
    localparam logic [7:0] CH_RCUR   = 8'h7D;

    typedef enum logic [KIND_BITS-1:0] {
        K_ID, K_LSQ, K_RSQ, K_SEMI, K_COMMA, K_LCUR, K_RCUR, K_COLON,
        K_LPAR, K_RPAR, K_MUL, K_MOD, K_EQEQ, K_ASSIGN, K_PLUS, K_INC, K_DEC,
        K_MINUS, K_LT, K_LE, K_NE, K_GT, K_GE, K_DIV, K_INT, K_DEC_NUM, K_STR,
        K_DOLLAR, K_AT, K_QUEST, K_HASH, K_EOF, K_ERR_BYTE, K_ERR_FLOAT,
        K_ERR_STR
    } kind_t;

    typedef enum logic [3:0] {
        S_START, S_IDENT, S_EQ, S_PLUS, S_MINUS, S_LT, S_GT, S_SLASH,
        S_LCOMM, S_BCOMM, S_BSTAR, S_INT, S_DOT, S_FRAC, S_STR
    } scan_state_t;

    typedef struct packed {
        kind_t                     kind;
        logic [SPAN_BITS-1:0]      span_start;
        logic [SPAN_BITS-1:0]      span_end;
        logic [LINE_OUT_BITS-1:0]  line;
    } token_rec_t;

    typedef struct packed {
        logic [1:0]  count;
        token_rec_t  rec0;
        token_rec_t  rec1;
    } scan_result_t;

endpackage

FILE: rtl/srclex_if.sv
interface lex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_source;

    modport source (output valid, output char_in, output end_of_source, input ready);
    modport sink (input valid, input char_in, input end_of_source, output ready);
endinterface

interface lex_token_if;
    logic                                  valid;
    logic                                  ready;
    logic [srclex_pkg::KIND_BITS-1:0]      token_kind;
    logic [srclex_pkg::SPAN_BITS-1:0]      span_start;
    logic [srclex_pkg::SPAN_BITS-1:0]      span_end;
    logic [srclex_pkg::LINE_OUT_BITS-1:0]  line_number;
    logic                                  last_of_run;

    modport source (output valid, output token_kind, output span_start, output span_end,
                    output line_number, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input span_start, input span_end,
                  input line_number, input last_of_run, output ready);
endinterface

FILE: rtl/srclex_scan.sv
module srclex_scan (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic [7:0]               char_in,
    input  logic                     end_of_source,
    output srclex_pkg::scan_result_t result
);
    import srclex_pkg::*;

    scan_state_t             state_reg, state_next;
    logic [OFFSET_BITS-1:0]  cur_reg, cur_next;
    logic [OFFSET_BITS-1:0]  tok_reg, tok_next;
    logic [LINE_BITS-1:0]    line_reg, line_next;

    logic [OFFSET_BITS-1:0]  off_inc;
    logic [LINE_BITS-1:0]    line_inc;
    logic                    c_alpha, c_digit, c_space, c_ident, c_nl;
    logic                    pend, pend_long, rescan, start_emit, tail_valid;
    kind_t                   pend_kind, start_kind;
    token_rec_t              rec_pend, rec_tail;

    assign off_inc  = (cur_reg == OFF_TOP) ? cur_reg : cur_reg + OFFSET_BITS'(1);
    assign line_inc = (line_reg == LINE_TOP) ? line_reg : line_reg + LINE_BITS'(1);

    assign c_alpha = (char_in >= CH_LO_A && char_in <= CH_LO_Z)
                   || (char_in >= CH_UP_A && char_in <= CH_UP_Z);
    assign c_digit = (char_in >= CH_0 && char_in <= CH_9);
    assign c_space = (char_in == CH_SPACE) || (char_in >= CH_TAB && char_in <= CH_CR);
    assign c_ident = c_alpha || c_digit || (char_in == CH_UNDER);
    assign c_nl    = (char_in == CH_NL);

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        tok_next   = tok_reg;
        line_next  = line_reg;
        pend       = 1'b0;
        pend_long  = 1'b0;
        pend_kind  = K_ID;
        rescan     = 1'b0;
        start_emit = 1'b0;
        start_kind = K_ERR_BYTE;

        if (end_of_source)
        begin
            // flush the pending token, then end of file
            pend = 1'b1;
            unique case (state_reg)
                S_IDENT: pend_kind = K_ID;
                S_EQ:    pend_kind = K_ASSIGN;
                S_PLUS:  pend_kind = K_PLUS;
                S_MINUS: pend_kind = K_MINUS;
                S_LT:    pend_kind = K_LT;
                S_GT:    pend_kind = K_GT;
                S_SLASH: pend_kind = K_DIV;
                S_INT:   pend_kind = K_INT;
                S_DOT:   pend_kind = K_ERR_FLOAT;
                S_FRAC:  pend_kind = K_DEC_NUM;
                S_STR:   pend_kind = K_ERR_STR;
                default: pend = 1'b0;
            endcase
            state_next = S_START;
            cur_next   = '0;
            tok_next   = '0;
            line_next  = LINE_ONE;
        end
        else
        begin
            unique case (state_reg)
                S_IDENT:
                begin
                    if (c_ident)
                        cur_next = off_inc;
                    else
                    begin
                        pend = 1'b1; pend_kind = K_ID; rescan = 1'b1;
                    end
                end
                S_EQ:
                begin
                    pend = 1'b1;
                    if (char_in == CH_EQ)
                    begin
                        pend_long = 1'b1; pend_kind = K_EQEQ;
                    end
                    else
                    begin
                        pend_kind = K_ASSIGN; rescan = 1'b1;
                    end
                end
                S_PLUS:
                begin
                    pend = 1'b1;
                    if (char_in == CH_PLUS)
                    begin
                        pend_long = 1'b1; pend_kind = K_INC;
                    end
                    else
                    begin
                        pend_kind = K_PLUS; rescan = 1'b1;
                    end
                end
                S_MINUS:
                begin
                    pend = 1'b1;
                    if (char_in == CH_MINUS)
                    begin
                        pend_long = 1'b1; pend_kind = K_DEC;
                    end
                    else
                    begin
                        pend_kind = K_MINUS; rescan = 1'b1;
                    end
                end
                S_LT:
                begin
                    pend = 1'b1;
                    priority if (char_in == CH_GT)
                    begin
                        pend_long = 1'b1; pend_kind = K_NE;
                    end
                    else if (char_in == CH_EQ)
                    begin
                        pend_long = 1'b1; pend_kind = K_LE;
                    end
                    else
                    begin
                        pend_kind = K_LT; rescan = 1'b1;
                    end
                end
                S_GT:
                begin
                    pend = 1'b1;
                    if (char_in == CH_EQ)
                    begin
                        pend_long = 1'b1; pend_kind = K_GE;
                    end
                    else
                    begin
                        pend_kind = K_GT; rescan = 1'b1;
                    end
                end
                S_SLASH:
                begin
                    priority if (char_in == CH_SLASH)
                    begin
                        cur_next = off_inc; state_next = S_LCOMM;
                    end
                    else if (char_in == CH_STAR)
                    begin
                        cur_next = off_inc; state_next = S_BCOMM;
                    end
                    else
                    begin
                        pend = 1'b1; pend_kind = K_DIV; rescan = 1'b1;
                    end
                end
                S_LCOMM:
                begin
                    cur_next = off_inc;
                    if (c_nl)
                    begin
                        line_next  = line_inc;
                        tok_next   = off_inc;
                        state_next = S_START;
                    end
                end
                S_BCOMM, S_BSTAR:
                begin
                    cur_next = off_inc;
                    if (state_reg == S_BSTAR && char_in == CH_SLASH)
                    begin
                        tok_next   = off_inc;
                        state_next = S_START;
                    end
                    else
                    begin
                        if (c_nl)
                            line_next = line_inc;
                        state_next = (char_in == CH_STAR) ? S_BSTAR : S_BCOMM;
                    end
                end
                S_INT:
                begin
                    priority if (c_digit)
                        cur_next = off_inc;
                    else if (char_in == CH_DOT)
                    begin
                        cur_next = off_inc; state_next = S_DOT;
                    end
                    else
                    begin
                        pend = 1'b1; pend_kind = K_INT; rescan = 1'b1;
                    end
                end
                S_DOT:
                begin
                    if (c_digit)
                    begin
                        cur_next = off_inc; state_next = S_FRAC;
                    end
                    else
                    begin
                        pend = 1'b1; pend_kind = K_ERR_FLOAT; rescan = 1'b1;
                    end
                end
                S_FRAC:
                begin
                    if (c_digit)
                        cur_next = off_inc;
                    else
                    begin
                        pend = 1'b1; pend_kind = K_DEC_NUM; rescan = 1'b1;
                    end
                end
                S_STR:
                begin
                    cur_next = off_inc;
                    if (char_in == CH_QUOTE)
                    begin
                        pend = 1'b1; pend_long = 1'b1; pend_kind = K_STR;
                    end
                end
                default: rescan = 1'b1;
            endcase

            if (pend_long)
            begin
                cur_next   = off_inc;
                state_next = S_START;
            end

            // scan the byte again from the start state
            if (rescan)
            begin
                state_next = S_START;
                tok_next   = cur_reg;
                cur_next   = off_inc;
                priority if (c_space)
                begin
                    tok_next = off_inc;
                    if (c_nl)
                        line_next = line_inc;
                end
                else if (c_alpha || char_in == CH_UNDER)
                    state_next = S_IDENT;
                else if (c_digit)
                    state_next = S_INT;
                else
                begin
                    start_emit = 1'b1;
                    unique case (char_in)
                        CH_LSQ:    start_kind = K_LSQ;
                        CH_RSQ:    start_kind = K_RSQ;
                        CH_SEMI:   start_kind = K_SEMI;
                        CH_COMMA:  start_kind = K_COMMA;
                        CH_LCUR:   start_kind = K_LCUR;
                        CH_RCUR:   start_kind = K_RCUR;
                        CH_COLON:  start_kind = K_COLON;
                        CH_LPAR:   start_kind = K_LPAR;
                        CH_RPAR:   start_kind = K_RPAR;
                        CH_STAR:   start_kind = K_MUL;
                        CH_PCT:    start_kind = K_MOD;
                        CH_DOLLAR: start_kind = K_DOLLAR;
                        CH_AT:     start_kind = K_AT;
                        CH_QUEST:  start_kind = K_QUEST;
                        CH_HASH:   start_kind = K_HASH;
                        CH_EQ:     begin start_emit = 1'b0; state_next = S_EQ;    end
                        CH_PLUS:   begin start_emit = 1'b0; state_next = S_PLUS;  end
                        CH_MINUS:  begin start_emit = 1'b0; state_next = S_MINUS; end
                        CH_LT:     begin start_emit = 1'b0; state_next = S_LT;    end
                        CH_GT:     begin start_emit = 1'b0; state_next = S_GT;    end
                        CH_SLASH:  begin start_emit = 1'b0; state_next = S_SLASH; end
                        CH_QUOTE:  begin start_emit = 1'b0; state_next = S_STR;   end
                        default:   start_kind = K_ERR_BYTE;
                    endcase
                end
            end
        end

        rec_pend.kind       = pend_kind;
        rec_pend.span_start = SPAN_BITS'(tok_reg);
        rec_pend.span_end   = pend_long ? SPAN_BITS'(off_inc) : SPAN_BITS'(cur_reg);
        rec_pend.line       = LINE_OUT_BITS'(line_reg);

        rec_tail.kind       = end_of_source ? K_EOF : start_kind;
        rec_tail.span_start = SPAN_BITS'(cur_reg);
        rec_tail.span_end   = end_of_source ? SPAN_BITS'(cur_reg) : SPAN_BITS'(off_inc);
        rec_tail.line       = LINE_OUT_BITS'(line_reg);

        tail_valid   = end_of_source || start_emit;
        result.count = {1'b0, pend} + {1'b0, tail_valid};
        result.rec0  = pend ? rec_pend : rec_tail;
        result.rec1  = rec_tail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_START;
            cur_reg   <= '0;
            tok_reg   <= '0;
            line_reg  <= LINE_ONE;
        end
        else if (load)
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            tok_reg   <= tok_next;
            line_reg  <= line_next;
        end
    end

endmodule

FILE: rtl/srclex_obuf.sv
module srclex_obuf (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  srclex_pkg::scan_result_t result,
    output logic                     can_accept,
    lex_token_if.source              tokens
);
    import srclex_pkg::*;

    logic [1:0]  cnt_reg, cnt_next;
    logic        head_reg, head_next;
    token_rec_t  rec0_reg, rec1_reg;
    token_rec_t  head_rec;
    logic        drain;

    assign drain      = tokens.valid && tokens.ready;
    assign can_accept = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && tokens.ready);

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        if (drain)
        begin
            if (cnt_reg == 2'd2)
            begin
                cnt_next  = 2'd1;
                head_next = 1'b1;
            end
            else
                cnt_next = 2'd0;
        end
        if (load && result.count != 2'd0)
        begin
            cnt_next  = result.count;
            head_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            head_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
        end
    end

    // hold the records of one item until both are taken
    always_ff @(posedge clk)
    begin
        if (load && result.count != 2'd0)
        begin
            rec0_reg <= result.rec0;
            rec1_reg <= result.rec1;
        end
    end

    assign head_rec           = head_reg ? rec1_reg : rec0_reg;
    assign tokens.valid       = (cnt_reg != 2'd0);
    assign tokens.token_kind  = head_rec.kind;
    assign tokens.span_start  = head_rec.span_start;
    assign tokens.span_end    = head_rec.span_end;
    assign tokens.line_number = head_rec.line;
    assign tokens.last_of_run = (cnt_reg == 2'd1);

endmodule

FILE: rtl/source_lexer_dfa.sv
// Streaming lexical scanner: one source byte per input item (or an end marker), token
// records out (kind, byte span, line, last-of-run flag). An item that produces no
// record or one record is taken every cycle unless the token port is back-pressured;
// an item that ends a pending token and starts a one-byte token, or the end marker
// after a pending token, gives two records, and the next item waits until the second
// has left. The scanner state advances on acceptance; the records of an item wait in
// a two-entry result buffer, and the next item is taken in the same cycle that the
// last buffered record leaves. The end marker flushes, emits end of file and returns
// the offsets to 0 and the line count to 1; offsets and line count saturate.
module source_lexer_dfa (
    input  logic        clk,
    input  logic        rst_n,
    lex_char_if.sink    chars,
    lex_token_if.source tokens
);
    import srclex_pkg::*;

    scan_result_t  result;
    logic          can_accept;
    logic          load;

    assign chars.ready = can_accept;
    assign load        = chars.valid && chars.ready;

    srclex_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .char_in       (chars.char_in),
        .end_of_source (chars.end_of_source),
        .result        (result)
    );

    srclex_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .result     (result),
        .can_accept (can_accept),
        .tokens     (tokens)
    );

endmodule

FILE: tb/source_lexer_dfa_test.sv
module source_lexer_dfa_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srclex_pkg::*;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    localparam int RANDOM_ITEMS  = 1000;
    localparam int STALL_LIMIT   = 400;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_PRINTED   = 30;

    // one-byte tokens, operators that may pair up, and whitespace
    localparam logic [8*15-1:0] PUNCT_SET = {CH_LSQ, CH_RSQ, CH_SEMI, CH_COMMA, CH_LCUR,
                                             CH_RCUR, CH_COLON, CH_LPAR, CH_RPAR, CH_STAR,
                                             CH_PCT, CH_DOLLAR, CH_AT, CH_QUEST, CH_HASH};
    localparam logic [8*12-1:0] PAIR_OPS  = {CH_EQ, CH_EQ, CH_PLUS, CH_PLUS, CH_MINUS,
                                             CH_MINUS, CH_LT, CH_EQ, CH_LT, CH_GT,
                                             CH_GT, CH_EQ};
    localparam logic [8*6-1:0]  LONE_OPS  = {CH_EQ, CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_SLASH};
    localparam logic [8*6-1:0]  BLANKS    = {CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};

    typedef struct packed {
        kind_t                     kind;
        logic [SPAN_BITS-1:0]      span_start;
        logic [SPAN_BITS-1:0]      span_end;
        logic [LINE_OUT_BITS-1:0]  line;
        logic                      last;
    } token_t;

    typedef struct {
        logic [7:0] ch;
        logic       eos;
        int         n_typed;
        token_t     r0;
        token_t     r1;
    } stim_row_t;

    logic clk;
    logic rst_n;

    lex_char_if  chars_bus ();
    lex_token_if tokens_bus ();

    source_lexer_dfa u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_bus),
        .tokens (tokens_bus)
    );

    always #5 clk = ~clk;

    // scanner copy used for prediction
    scan_state_t            lx_state;
    logic [OFFSET_BITS-1:0] lx_pos;
    logic [OFFSET_BITS-1:0] lx_tok_start;
    logic [LINE_BITS-1:0]   lx_line;

    token_t    step_tokens[$];
    token_t    expected_tokens[$];
    token_t    typed_tokens[$];
    bit        typed_pending;
    stim_row_t stim_rows[$];
    logic [7:0] src_text[$];

    bit no_idle;
    int error_count;
    int records_checked;
    int bytes_seen;
    int markers_seen;
    int quiet_cycles;

    function automatic bit is_letter(logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void advance_pos();
        if (lx_pos != OFF_TOP)
            lx_pos = lx_pos + OFFSET_BITS'(1);
    endfunction

    function automatic void bump_line();
        if (lx_line != LINE_TOP)
            lx_line = lx_line + LINE_BITS'(1);
    endfunction

    function automatic void add_token(kind_t k);
        token_t t;
        if (step_tokens.size() < 2)
        begin
            t.kind       = k;
            t.span_start = lx_tok_start[SPAN_BITS-1:0];
            t.span_end   = lx_pos[SPAN_BITS-1:0];
            t.line       = lx_line[LINE_OUT_BITS-1:0];
            t.last       = 1'b0;
            step_tokens  = {step_tokens, t};
        end
    endfunction

    function automatic void close_token(kind_t k);
        add_token(k);
        lx_state = S_START;
    endfunction

    function automatic void clear_scanner();
        lx_state     = S_START;
        lx_pos       = '0;
        lx_tok_start = '0;
        lx_line      = LINE_ONE;
    endfunction

    function automatic void lex_from_start(logic [7:0] c);
        lx_tok_start = lx_pos;
        if (is_blank(c))
        begin
            if (c == CH_NL)
                bump_line();
            advance_pos();
            lx_tok_start = lx_pos;
            return;
        end
        advance_pos();
        if (is_letter(c) || c == CH_UNDER)
            lx_state = S_IDENT;
        else if (is_digit(c))
            lx_state = S_INT;
        else
        begin
            case (c)
                CH_LSQ:    add_token(K_LSQ);
                CH_RSQ:    add_token(K_RSQ);
                CH_SEMI:   add_token(K_SEMI);
                CH_COMMA:  add_token(K_COMMA);
                CH_LCUR:   add_token(K_LCUR);
                CH_RCUR:   add_token(K_RCUR);
                CH_COLON:  add_token(K_COLON);
                CH_LPAR:   add_token(K_LPAR);
                CH_RPAR:   add_token(K_RPAR);
                CH_STAR:   add_token(K_MUL);
                CH_PCT:    add_token(K_MOD);
                CH_DOLLAR: add_token(K_DOLLAR);
                CH_AT:     add_token(K_AT);
                CH_QUEST:  add_token(K_QUEST);
                CH_HASH:   add_token(K_HASH);
                CH_EQ:     lx_state = S_EQ;
                CH_PLUS:   lx_state = S_PLUS;
                CH_MINUS:  lx_state = S_MINUS;
                CH_LT:     lx_state = S_LT;
                CH_GT:     lx_state = S_GT;
                CH_SLASH:  lx_state = S_SLASH;
                CH_QUOTE:  lx_state = S_STR;
                default:   add_token(K_ERR_BYTE);
            endcase
        end
    endfunction

    function automatic void comment_byte(logic [7:0] c);
        if (c == CH_NL)
            bump_line();
        advance_pos();
        lx_state = (c == CH_STAR) ? S_BSTAR : S_BCOMM;
    endfunction

    function automatic void lex_byte(logic [7:0] c);
        bit rescan;
        rescan = 1'b0;
        case (lx_state)
            S_IDENT:
                if (is_letter(c) || is_digit(c) || c == CH_UNDER)
                    advance_pos();
                else
                begin
                    close_token(K_ID);
                    rescan = 1'b1;
                end
            S_EQ:
                if (c == CH_EQ)
                begin
                    advance_pos();
                    close_token(K_EQEQ);
                end
                else
                begin
                    close_token(K_ASSIGN);
                    rescan = 1'b1;
                end
            S_PLUS:
                if (c == CH_PLUS)
                begin
                    advance_pos();
                    close_token(K_INC);
                end
                else
                begin
                    close_token(K_PLUS);
                    rescan = 1'b1;
                end
            S_MINUS:
                if (c == CH_MINUS)
                begin
                    advance_pos();
                    close_token(K_DEC);
                end
                else
                begin
                    close_token(K_MINUS);
                    rescan = 1'b1;
                end
            S_LT:
                if (c == CH_GT)
                begin
                    advance_pos();
                    close_token(K_NE);
                end
                else if (c == CH_EQ)
                begin
                    advance_pos();
                    close_token(K_LE);
                end
                else
                begin
                    close_token(K_LT);
                    rescan = 1'b1;
                end
            S_GT:
                if (c == CH_EQ)
                begin
                    advance_pos();
                    close_token(K_GE);
                end
                else
                begin
                    close_token(K_GT);
                    rescan = 1'b1;
                end
            S_SLASH:
                if (c == CH_SLASH)
                begin
                    advance_pos();
                    lx_state = S_LCOMM;
                end
                else if (c == CH_STAR)
                begin
                    advance_pos();
                    lx_state = S_BCOMM;
                end
                else
                begin
                    close_token(K_DIV);
                    rescan = 1'b1;
                end
            S_LCOMM:
            begin
                advance_pos();
                if (c == CH_NL)
                begin
                    bump_line();
                    lx_tok_start = lx_pos;
                    lx_state     = S_START;
                end
            end
            S_BCOMM:
                comment_byte(c);
            S_BSTAR:
                if (c == CH_SLASH)
                begin
                    advance_pos();
                    lx_tok_start = lx_pos;
                    lx_state     = S_START;
                end
                else
                    comment_byte(c);
            S_INT:
                if (is_digit(c))
                    advance_pos();
                else if (c == CH_DOT)
                begin
                    advance_pos();
                    lx_state = S_DOT;
                end
                else
                begin
                    close_token(K_INT);
                    rescan = 1'b1;
                end
            S_DOT:
                if (is_digit(c))
                begin
                    advance_pos();
                    lx_state = S_FRAC;
                end
                else
                begin
                    close_token(K_ERR_FLOAT);
                    rescan = 1'b1;
                end
            S_FRAC:
                if (is_digit(c))
                    advance_pos();
                else
                begin
                    close_token(K_DEC_NUM);
                    rescan = 1'b1;
                end
            S_STR:
            begin
                advance_pos();
                if (c == CH_QUOTE)
                    close_token(K_STR);
            end
            default:
            begin
                lx_state = S_START;
                rescan   = 1'b1;
            end
        endcase
        if (rescan)
            lex_from_start(c);
    endfunction

    function automatic void lex_end();
        case (lx_state)
            S_IDENT: add_token(K_ID);
            S_EQ:    add_token(K_ASSIGN);
            S_PLUS:  add_token(K_PLUS);
            S_MINUS: add_token(K_MINUS);
            S_LT:    add_token(K_LT);
            S_GT:    add_token(K_GT);
            S_SLASH: add_token(K_DIV);
            S_INT:   add_token(K_INT);
            S_DOT:   add_token(K_ERR_FLOAT);
            S_FRAC:  add_token(K_DEC_NUM);
            S_STR:   add_token(K_ERR_STR);
            default: ;
        endcase
        lx_tok_start = lx_pos;
        add_token(K_EOF);
        clear_scanner();
    endfunction

    function automatic void predict_item(logic [7:0] c, logic eos);
        token_t t;
        step_tokens.delete();
        if (eos)
            lex_end();
        else
            lex_byte(c);
        if (step_tokens.size() > 0)
        begin
            t           = step_tokens.pop_back();
            t.last      = 1'b1;
            step_tokens = {step_tokens, t};
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_token();
        token_t want;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch($sformatf("record kind %0d [%0d,%0d) with nothing pending",
                                      tokens_bus.token_kind, tokens_bus.span_start,
                                      tokens_bus.span_end));
            return;
        end
        want = expected_tokens.pop_front();
        if (tokens_bus.token_kind !== want.kind || tokens_bus.span_start !== want.span_start ||
            tokens_bus.span_end !== want.span_end || tokens_bus.line_number !== want.line ||
            tokens_bus.last_of_run !== want.last)
            report_mismatch($sformatf(
                "record %0d: got %0d [%0d,%0d) ln %0d last %0b, want %0d [%0d,%0d) ln %0d last %0b",
                records_checked, tokens_bus.token_kind, tokens_bus.span_start,
                tokens_bus.span_end, tokens_bus.line_number, tokens_bus.last_of_run,
                want.kind, want.span_start, want.span_end, want.line, want.last));
        records_checked++;
    endtask

    // predict on every accepted byte, then check whatever record leaves this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (chars_bus.valid && chars_bus.ready)
            begin
                predict_item(chars_bus.char_in, chars_bus.end_of_source);
                if (chars_bus.end_of_source)
                    markers_seen++;
                else
                    bytes_seen++;
                if (typed_pending)
                begin
                    foreach (typed_tokens[i])
                        expected_tokens = {expected_tokens, typed_tokens[i]};
                    typed_pending = 1'b0;
                end
                else
                begin
                    foreach (step_tokens[i])
                        expected_tokens = {expected_tokens, step_tokens[i]};
                end
            end
            if (tokens_bus.valid && tokens_bus.ready)
                check_token();
            if ((chars_bus.valid && chars_bus.ready) || (tokens_bus.valid && tokens_bus.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("timeout: no item moved for %0d cycles, %0d records pending",
                             quiet_cycles, expected_tokens.size());
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

    // token receiver with random back-pressure
    initial
    begin
        int gap;
        tokens_bus.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 13);
            if (gap > 0)
            begin
                tokens_bus.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            tokens_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(tokens_bus.valid && tokens_bus.ready));
            @(negedge clk);
        end
    end

    task automatic send_char(input logic [7:0] c, input logic eos);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            chars_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        chars_bus.valid         <= 1'b1;
        chars_bus.char_in       <= c;
        chars_bus.end_of_source <= eos;
        do
            @(posedge clk);
        while (!(chars_bus.valid && chars_bus.ready));
        @(negedge clk);
    endtask

    function automatic token_t tok(kind_t k, int s, int e, int ln, bit last);
        token_t t;
        t.kind       = k;
        t.span_start = SPAN_BITS'(s);
        t.span_end   = SPAN_BITS'(e);
        t.line       = LINE_OUT_BITS'(ln);
        t.last       = last;
        return t;
    endfunction

    function automatic void stim_row(logic [7:0] ch, logic eos, int n = 0,
                                     token_t r0 = '0, token_t r1 = '0);
        stim_row_t r;
        r.ch      = ch;
        r.eos     = eos;
        r.n_typed = n;
        r.r0      = r0;
        r.r1      = r1;
        stim_rows = {stim_rows, r};
    endfunction

    function automatic void append_byte(logic [7:0] b);
        src_text = {src_text, b};
    endfunction

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26)
            return CH_LO_A + 8'(r);
        else if (r < 52)
            return CH_UP_A + 8'(r - 26);
        else if (r < 62)
            return CH_0 + 8'(r - 52);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] any_digit();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic void add_digits(int lo, int hi);
        repeat ($urandom_range(lo, hi)) append_byte(any_digit());
    endfunction

    // append one well-formed lexeme (or a broken one, or noise) to the source text
    function automatic void add_snippet();
        int sel;
        int r;
        logic [7:0] b;
        sel = $urandom_range(0, 15);
        case (sel)
            0, 1:
            begin
                r = $urandom_range(0, 52);
                append_byte(r < 26 ? CH_LO_A + 8'(r) :
                            r < 52 ? CH_UP_A + 8'(r - 26) : CH_UNDER);
                repeat ($urandom_range(0, 6)) append_byte(word_char());
            end
            2: add_digits(1, 5);
            3:
            begin
                add_digits(1, 4);
                append_byte(CH_DOT);
                add_digits(1, 4);
            end
            4:
            begin
                add_digits(1, 3);
                append_byte(CH_DOT);
                append_byte($urandom_range(0, 1) ? word_char() : CH_SEMI);
            end
            5, 6:
            begin
                append_byte(CH_QUOTE);
                repeat ($urandom_range(0, 6))
                begin
                    b = ($urandom_range(0, 7) == 0) ? CH_NL : 8'($urandom_range(0, 255));
                    append_byte(b == CH_QUOTE ? CH_SPACE : b);
                end
                // leave some strings open
                if (sel == 5)
                    append_byte(CH_QUOTE);
            end
            7:
            begin
                append_byte(CH_SLASH);
                append_byte(CH_SLASH);
                repeat ($urandom_range(0, 6))
                begin
                    b = 8'($urandom_range(0, 255));
                    append_byte(b == CH_NL ? CH_SPACE : b);
                end
                append_byte(CH_NL);
            end
            8:
            begin
                append_byte(CH_SLASH);
                append_byte(CH_STAR);
                repeat ($urandom_range(0, 6))
                begin
                    r = $urandom_range(0, 5);
                    append_byte(r == 0 ? CH_STAR : r == 1 ? CH_NL :
                                r == 2 ? CH_SLASH : word_char());
                end
                append_byte(CH_STAR);
                append_byte(CH_SLASH);
            end
            9, 10: append_byte(PUNCT_SET[8*$urandom_range(0, 14) +: 8]);
            11:
            begin
                r = $urandom_range(0, 5);
                append_byte(PAIR_OPS[16*r+8 +: 8]);
                append_byte(PAIR_OPS[16*r +: 8]);
            end
            12: append_byte(LONE_OPS[8*$urandom_range(0, 5) +: 8]);
            13: repeat ($urandom_range(1, 3)) append_byte(BLANKS[8*$urandom_range(0, 5) +: 8]);
            default: append_byte(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 1))
            append_byte(BLANKS[8*$urandom_range(0, 5) +: 8]);
    endfunction

    initial
    begin
        int random_items;
        clk                     = 1'b0;
        rst_n                   = 1'b0;
        chars_bus.valid         = 1'b0;
        chars_bus.char_in       = '0;
        chars_bus.end_of_source = 1'b0;
        no_idle                 = 1'b0;
        typed_pending           = 1'b0;
        error_count             = 0;
        records_checked         = 0;
        bytes_seen              = 0;
        markers_seen            = 0;
        quiet_cycles            = 0;
        random_items            = 0;
        clear_scanner();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows; a typed result replaces the prediction for that item
        stim_row(CH_LSQ,  1'b0, 1, tok(K_LSQ, 0, 1, 1, 1));
        stim_row(CH_LO_A, 1'b0);
        stim_row(CH_PLUS, 1'b0, 1, tok(K_ID, 1, 2, 1, 1));
        stim_row(CH_PLUS, 1'b0, 1, tok(K_INC, 2, 4, 1, 1));
        stim_row(8'hFF,   1'b0, 1, tok(K_ERR_BYTE, 4, 5, 1, 1));
        stim_row(CH_9,    1'b0);
        stim_row(CH_DOT,  1'b0);
        stim_row(CH_LO_Z, 1'b0, 1, tok(K_ERR_FLOAT, 5, 7, 1, 1));
        stim_row(CH_SEMI, 1'b0, 2, tok(K_ID, 7, 8, 1, 0), tok(K_SEMI, 8, 9, 1, 1));
        stim_row(CH_QUOTE, 1'b0);
        stim_row(CH_NL,   1'b0);
        stim_row(8'hA5,   1'b1, 2, tok(K_ERR_STR, 9, 11, 1, 0), tok(K_EOF, 11, 11, 1, 1));
        stim_row(CH_SLASH, 1'b0);
        stim_row(CH_SLASH, 1'b0);
        stim_row(CH_UP_Z, 1'b0);
        stim_row(8'h5A,   1'b1, 1, tok(K_EOF, 3, 3, 1, 1));
        stim_row(CH_SLASH, 1'b0);
        stim_row(CH_STAR, 1'b0);
        stim_row(CH_NL,   1'b0);
        stim_row(8'h00,   1'b1, 1, tok(K_EOF, 3, 3, 2, 1));
        stim_row(CH_0,    1'b0);
        stim_row(CH_DOT,  1'b0);
        stim_row(8'hFF,   1'b1, 2, tok(K_ERR_FLOAT, 0, 2, 1, 0), tok(K_EOF, 2, 2, 1, 1));
        stim_row(8'h7F,   1'b1, 1, tok(K_EOF, 0, 0, 1, 1));
        stim_row(8'h80,   1'b0, 1, tok(K_ERR_BYTE, 0, 1, 1, 1));
        stim_row(CH_LT,   1'b0);
        stim_row(CH_GT,   1'b0);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].n_typed > 0)
            begin
                typed_tokens.delete();
                typed_tokens = {typed_tokens, stim_rows[i].r0};
                if (stim_rows[i].n_typed > 1)
                    typed_tokens = {typed_tokens, stim_rows[i].r1};
                typed_pending = 1'b1;
            end
            send_char(stim_rows[i].ch, stim_rows[i].eos);
        end

        while (random_items < RANDOM_ITEMS)
        begin
            src_text.delete();
            repeat ($urandom_range(3, 25)) add_snippet();
            no_idle = ($urandom_range(0, 3) == 0);
            foreach (src_text[i])
            begin
                send_char(src_text[i], 1'b0);
                random_items++;
            end
            // most programs end with the marker; the rest run on into the next
            if ($urandom_range(0, 9) != 0)
            begin
                send_char(8'($urandom_range(0, 255)), 1'b1);
                random_items++;
            end
        end
        no_idle = 1'b0;
        send_char(8'($urandom_range(0, 255)), 1'b1);
        chars_bus.valid <= 1'b0;

        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d source bytes and %0d end markers, %0d token records checked",
                 bytes_seen, markers_seen, records_checked);
        $display("mismatches found: %0d", error_count);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
rtl/srclex_pkg.sv
rtl/srclex_if.sv
rtl/srclex_scan.sv
rtl/srclex_obuf.sv
rtl/source_lexer_dfa.sv
tb/source_lexer_dfa_test.sv
